>>> hdl/scf_pkg.sv
// Shared types, constants and helpers for the stereo crossfeed filter.
// No dependencies; every other file in hdl/ imports this package.
package scf_pkg;

   localparam int SAMPLE_BITS_DEF = 24;
   localparam int COEF_BITS_DEF   = 24;
   localparam int STATE_BITS      = 32;
   // rounded product: coef * state >> (COEF_BITS-2) fits in STATE_BITS+3
   localparam int PROD_BITS       = STATE_BITS + 3;
   // room for the sum of three rounded products
   localparam int SUM_BITS        = STATE_BITS + 5;
   localparam int NUM_REGS        = 6;
   localparam int CSR_ADDR_BITS   = 5;
   localparam int CSR_DATA_BITS   = 32;
   localparam int NUM_LANES       = 10;

   typedef enum logic [2:0] {
      REG_LP_GAIN  = 3'd0,
      REG_LP_FB    = 3'd1,
      REG_HS_GAIN  = 3'd2,
      REG_HS_PREV  = 3'd3,
      REG_HS_FB    = 3'd4,
      REG_OUT_GAIN = 3'd5
   } reg_index_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_MUL1,
      ST_RND1,
      ST_UPD,
      ST_XSUM,
      ST_MUL2,
      ST_RND2,
      ST_OUT
   } seq_state_type;

   // control for one serial multiplier lane
   typedef struct packed {
      logic load;
      logic step;
      logic last;
      logic fin;
   } mul_ctrl_type;

   localparam logic signed [SUM_BITS-1:0] STATE_MAX_EXT =
      {{(SUM_BITS-STATE_BITS+1){1'b0}}, {(STATE_BITS-1){1'b1}}};
   localparam logic signed [SUM_BITS-1:0] STATE_MIN_EXT = ~STATE_MAX_EXT;

   function automatic logic signed [STATE_BITS-1:0] sat_state(
      input logic signed [SUM_BITS-1:0] v);
      logic signed [SUM_BITS-1:0] r;
      r = v;
      if (v > STATE_MAX_EXT) begin
         r = STATE_MAX_EXT;
      end else if (v < STATE_MIN_EXT) begin
         r = STATE_MIN_EXT;
      end
      return r[STATE_BITS-1:0];
   endfunction

endpackage

>>> hdl/scf_csr.sv
// Coefficient register file behind the APB-style configuration port.
// Depends on scf_pkg.
module scf_csr #(
   parameter int COEF_BITS = scf_pkg::COEF_BITS_DEF
) (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  psel,
   input  logic                                  penable,
   input  logic                                  pwrite,
   input  logic [scf_pkg::CSR_ADDR_BITS-1:0]     paddr,
   input  logic [scf_pkg::CSR_DATA_BITS-1:0]     pwdata,
   output logic [scf_pkg::CSR_DATA_BITS-1:0]     prdata,
   output logic signed [COEF_BITS-1:0]           coef [scf_pkg::NUM_REGS]
);
   import scf_pkg::*;

   logic signed [COEF_BITS-1:0] coef_ff [NUM_REGS];
   logic signed [COEF_BITS-1:0] coef_in [NUM_REGS];
   logic [2:0]                  idx;
   logic                        idx_ok;
   logic                        wr_en;

   assign idx    = paddr[4:2];
   assign idx_ok = (idx < 3'(NUM_REGS));
   assign wr_en  = psel & penable & pwrite & idx_ok;

   always_comb begin
      for (int i = 0; i < NUM_REGS; i++) begin
         coef_in[i] = coef_ff[i];
      end
      if (wr_en) begin
         coef_in[idx] = pwdata[COEF_BITS-1:0];
      end
   end

   always_ff @(posedge clock) begin
      for (int i = 0; i < NUM_REGS; i++) begin
         if (reset) begin
            coef_ff[i] <= '0;
         end else begin
            coef_ff[i] <= coef_in[i];
         end
      end
   end

   always_comb begin
      prdata = '0;
      if (idx_ok) begin
         prdata = CSR_DATA_BITS'(coef_ff[idx]);
      end
   end

   assign coef = coef_ff;

endmodule

>>> hdl/scf_serial_mul.sv
// Bit-serial signed multiplier: one coefficient bit per cycle while ctrl.step
// is high, LSB first, followed by a round-half-up shift by COEF_BITS-2. Depends on scf_pkg.
module scf_serial_mul #(
   parameter int COEF_BITS = scf_pkg::COEF_BITS_DEF
) (
   input  logic                                   clock,
   input  scf_pkg::mul_ctrl_type                  ctrl,
   input  logic signed [COEF_BITS-1:0]            coef,
   input  logic signed [scf_pkg::STATE_BITS-1:0]  operand,
   output logic signed [scf_pkg::PROD_BITS-1:0]   product
);
   import scf_pkg::*;

   localparam int ACC_BITS = STATE_BITS + 1;

   logic [COEF_BITS-1:0]         coef_ff, coef_in;
   logic signed [STATE_BITS-1:0] opnd_ff, opnd_in;
   logic [ACC_BITS-1:0]          acc_ff, acc_in;
   logic [COEF_BITS-1:0]         low_ff, low_in;
   logic [PROD_BITS-1:0]         prod_ff, prod_in;
   logic signed [ACC_BITS:0]     term;
   logic [ACC_BITS:0]            sum;
   logic [PROD_BITS-1:0]         rounded;

   always_comb begin
      term = '0;
      if (coef_ff[0]) begin
         // sign bit of the coefficient carries negative weight
         term = ctrl.last ? -((ACC_BITS+1)'(opnd_ff)) : (ACC_BITS+1)'(opnd_ff);
      end
      sum = {acc_ff[ACC_BITS-1], acc_ff} + term;
      // floor(P / 2^k) plus bit k-1 of P gives round half up
      rounded = {acc_ff, low_ff[COEF_BITS-1 -: 2]}
              + PROD_BITS'(low_ff[COEF_BITS-3]);
   end

   always_comb begin
      coef_in = coef_ff;
      opnd_in = opnd_ff;
      acc_in  = acc_ff;
      low_in  = low_ff;
      prod_in = prod_ff;
      if (ctrl.load) begin
         coef_in = coef;
         opnd_in = operand;
         acc_in  = '0;
      end else if (ctrl.step) begin
         coef_in = coef_ff >> 1;
         acc_in  = sum[ACC_BITS:1];
         low_in  = {sum[0], low_ff[COEF_BITS-1:1]};
      end
      if (ctrl.fin) begin
         prod_in = rounded;
      end
   end

   always_ff @(posedge clock) begin
      coef_ff <= coef_in;
      opnd_ff <= opnd_in;
      acc_ff  <= acc_in;
      low_ff  <= low_in;
      prod_ff <= prod_in;
   end

   assign product = prod_ff;

endmodule

>>> hdl/stereo_crossfeed_filter.sv
// Top level of the stereo crossfeed filter: sequencer, filter state, lanes.
// Depends on scf_pkg, scf_csr and scf_serial_mul.
//
//   beat       ports                                       handshake
//   --------   -----------------------------------------   ----------------------
//   request    req_left_in, req_right_in, req_last_frame   req_valid / req_stall
//   response   rsp_left_out, rsp_right_out,
//              rsp_last_frame_out                          rsp_valid / rsp_stall
//   config     psel, penable, pwrite, paddr, pwdata,
//              prdata, pready                              APB, pready tied high
//
// Per frame, ten bit-serial lanes run the filter products in parallel, then two
// of them run the output gain, each pass stepping through every coefficient bit;
// a new frame is accepted only once the sequencer is back in idle.
// The result register lets a new frame be taken while a response is stalled;
// the sequencer waits in its last state only if that register is still full.
// Synchronous reset clears coefficients, filter state and handshake state.
module stereo_crossfeed_filter #(
   parameter int SAMPLE_BITS = scf_pkg::SAMPLE_BITS_DEF,
   parameter int COEF_BITS   = scf_pkg::COEF_BITS_DEF
) (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               req_valid,
   output logic                               req_stall,
   input  logic signed [SAMPLE_BITS-1:0]      req_left_in,
   input  logic signed [SAMPLE_BITS-1:0]      req_right_in,
   input  logic                               req_last_frame,
   output logic                               rsp_valid,
   input  logic                               rsp_stall,
   output logic signed [SAMPLE_BITS-1:0]      rsp_left_out,
   output logic signed [SAMPLE_BITS-1:0]      rsp_right_out,
   output logic                               rsp_last_frame_out,
   input  logic                               psel,
   input  logic                               penable,
   input  logic                               pwrite,
   input  logic [scf_pkg::CSR_ADDR_BITS-1:0]  paddr,
   input  logic [scf_pkg::CSR_DATA_BITS-1:0]  pwdata,
   output logic [scf_pkg::CSR_DATA_BITS-1:0]  prdata,
   output logic                               pready
);
   import scf_pkg::*;

   localparam int CNT_BITS = $clog2(COEF_BITS);
   localparam logic [CNT_BITS-1:0] CNT_LAST = CNT_BITS'(COEF_BITS - 1);

   // lane assignment for the filter pass; lanes 0 and 1 also do the gain pass
   localparam int L_LP_XL = 0;
   localparam int L_LP_XR = 1;
   localparam int L_LP_YL = 2;
   localparam int L_LP_YR = 3;
   localparam int L_HS_XL = 4;
   localparam int L_HS_XR = 5;
   localparam int L_HS_PL = 6;
   localparam int L_HS_PR = 7;
   localparam int L_HS_YL = 8;
   localparam int L_HS_YR = 9;

   localparam logic signed [PROD_BITS-1:0] OUT_MAX =
      {{(PROD_BITS-SAMPLE_BITS+1){1'b0}}, {(SAMPLE_BITS-1){1'b1}}};
   localparam logic signed [PROD_BITS-1:0] OUT_MIN = ~OUT_MAX;

   logic signed [COEF_BITS-1:0]  coef [NUM_REGS];

   seq_state_type                state_ff, state_in;
   logic [CNT_BITS-1:0]          cnt_ff, cnt_in;
   logic                         accept;
   logic                         out_free;
   logic                         out_write;
   logic                         cnt_last;
   mul_ctrl_type                 ctrl_filt, ctrl_gain;

   mul_ctrl_type                 lane_ctrl [NUM_LANES];
   logic signed [COEF_BITS-1:0]  lane_coef [NUM_LANES];
   logic signed [STATE_BITS-1:0] lane_opnd [NUM_LANES];
   logic signed [PROD_BITS-1:0]  lane_prod [NUM_LANES];

   logic signed [STATE_BITS-1:0] lp_l_ff, lp_l_in, lp_r_ff, lp_r_in;
   logic signed [STATE_BITS-1:0] hs_l_ff, hs_l_in, hs_r_ff, hs_r_in;
   logic signed [SAMPLE_BITS-1:0] prev_l_ff, prev_l_in, prev_r_ff, prev_r_in;
   logic signed [SAMPLE_BITS-1:0] x_l_ff, x_l_in, x_r_ff, x_r_in;
   logic                         last_ff, last_in;
   logic signed [STATE_BITS-1:0] xsum_l, xsum_r;

   logic                         rsp_valid_ff, rsp_valid_in;
   logic signed [SAMPLE_BITS-1:0] rsp_left_ff, rsp_left_in;
   logic signed [SAMPLE_BITS-1:0] rsp_right_ff, rsp_right_in;
   logic                         rsp_last_ff, rsp_last_in;
   logic signed [PROD_BITS-1:0]  sat_l, sat_r;

   scf_csr #(
      .COEF_BITS (COEF_BITS)
   ) u_csr (
      .clock   (clock),
      .reset   (reset),
      .psel    (psel),
      .penable (penable),
      .pwrite  (pwrite),
      .paddr   (paddr),
      .pwdata  (pwdata),
      .prdata  (prdata),
      .coef    (coef)
   );

   assign pready = 1'b1;

   // sequencer
   assign req_stall = (state_ff != ST_IDLE);
   assign accept    = req_valid & ~req_stall;
   assign cnt_last  = (cnt_ff == CNT_LAST);
   assign out_free  = ~rsp_valid_ff | ~rsp_stall;

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (accept) state_in = ST_MUL1;
         end
         ST_MUL1: begin
            if (cnt_last) state_in = ST_RND1;
         end
         ST_RND1: state_in = ST_UPD;
         ST_UPD:  state_in = ST_XSUM;
         ST_XSUM: state_in = ST_MUL2;
         ST_MUL2: begin
            if (cnt_last) state_in = ST_RND2;
         end
         ST_RND2: state_in = ST_OUT;
         ST_OUT: begin
            if (out_free) state_in = ST_IDLE;
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_comb begin
      ctrl_filt = '0;
      ctrl_gain = '0;
      cnt_in    = '0;
      out_write = 1'b0;
      case (state_ff)
         ST_IDLE: ctrl_filt.load = accept;
         ST_MUL1: begin
            ctrl_filt.step = 1'b1;
            ctrl_filt.last = cnt_last;
            cnt_in         = cnt_last ? '0 : cnt_ff + 1'b1;
         end
         ST_RND1: ctrl_filt.fin = 1'b1;
         ST_XSUM: ctrl_gain.load = 1'b1;
         ST_MUL2: begin
            ctrl_gain.step = 1'b1;
            ctrl_gain.last = cnt_last;
            cnt_in         = cnt_last ? '0 : cnt_ff + 1'b1;
         end
         ST_RND2: ctrl_gain.fin = 1'b1;
         ST_OUT:  out_write = out_free;
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         cnt_ff   <= '0;
      end else begin
         state_ff <= state_in;
         cnt_ff   <= cnt_in;
      end
   end

   // crossfeed sums from the freshly updated state
   assign xsum_l = sat_state(SUM_BITS'(hs_l_ff) + SUM_BITS'(lp_r_ff));
   assign xsum_r = sat_state(SUM_BITS'(hs_r_ff) + SUM_BITS'(lp_l_ff));

   // lane inputs
   always_comb begin
      for (int i = 0; i < NUM_LANES; i++) begin
         lane_ctrl[i] = ctrl_filt;
      end
      lane_ctrl[L_LP_XL] = ctrl_filt | ctrl_gain;
      lane_ctrl[L_LP_XR] = ctrl_filt | ctrl_gain;

      lane_coef[L_LP_XL] = coef[REG_LP_GAIN];
      lane_opnd[L_LP_XL] = STATE_BITS'(req_left_in);
      lane_coef[L_LP_XR] = coef[REG_LP_GAIN];
      lane_opnd[L_LP_XR] = STATE_BITS'(req_right_in);
      if (state_ff == ST_XSUM) begin
         lane_coef[L_LP_XL] = coef[REG_OUT_GAIN];
         lane_opnd[L_LP_XL] = xsum_l;
         lane_coef[L_LP_XR] = coef[REG_OUT_GAIN];
         lane_opnd[L_LP_XR] = xsum_r;
      end
      lane_coef[L_LP_YL] = coef[REG_LP_FB];
      lane_opnd[L_LP_YL] = lp_l_ff;
      lane_coef[L_LP_YR] = coef[REG_LP_FB];
      lane_opnd[L_LP_YR] = lp_r_ff;
      lane_coef[L_HS_XL] = coef[REG_HS_GAIN];
      lane_opnd[L_HS_XL] = STATE_BITS'(req_left_in);
      lane_coef[L_HS_XR] = coef[REG_HS_GAIN];
      lane_opnd[L_HS_XR] = STATE_BITS'(req_right_in);
      lane_coef[L_HS_PL] = coef[REG_HS_PREV];
      lane_opnd[L_HS_PL] = STATE_BITS'(prev_l_ff);
      lane_coef[L_HS_PR] = coef[REG_HS_PREV];
      lane_opnd[L_HS_PR] = STATE_BITS'(prev_r_ff);
      lane_coef[L_HS_YL] = coef[REG_HS_FB];
      lane_opnd[L_HS_YL] = hs_l_ff;
      lane_coef[L_HS_YR] = coef[REG_HS_FB];
      lane_opnd[L_HS_YR] = hs_r_ff;
   end

   for (genvar g = 0; g < NUM_LANES; g++) begin : g_lane
      scf_serial_mul #(
         .COEF_BITS (COEF_BITS)
      ) u_mul (
         .clock   (clock),
         .ctrl    (lane_ctrl[g]),
         .coef    (lane_coef[g]),
         .operand (lane_opnd[g]),
         .product (lane_prod[g])
      );
   end

   // filter state
   always_comb begin
      lp_l_in   = lp_l_ff;
      lp_r_in   = lp_r_ff;
      hs_l_in   = hs_l_ff;
      hs_r_in   = hs_r_ff;
      prev_l_in = prev_l_ff;
      prev_r_in = prev_r_ff;
      x_l_in    = x_l_ff;
      x_r_in    = x_r_ff;
      last_in   = last_ff;
      if (accept) begin
         x_l_in  = req_left_in;
         x_r_in  = req_right_in;
         last_in = req_last_frame;
      end
      if (state_ff == ST_UPD) begin
         lp_l_in = sat_state(SUM_BITS'(lane_prod[L_LP_XL])
                           + SUM_BITS'(lane_prod[L_LP_YL]));
         lp_r_in = sat_state(SUM_BITS'(lane_prod[L_LP_XR])
                           + SUM_BITS'(lane_prod[L_LP_YR]));
         hs_l_in = sat_state(SUM_BITS'(lane_prod[L_HS_XL])
                           + SUM_BITS'(lane_prod[L_HS_PL])
                           + SUM_BITS'(lane_prod[L_HS_YL]));
         hs_r_in = sat_state(SUM_BITS'(lane_prod[L_HS_XR])
                           + SUM_BITS'(lane_prod[L_HS_PR])
                           + SUM_BITS'(lane_prod[L_HS_YR]));
         prev_l_in = x_l_ff;
         prev_r_in = x_r_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         lp_l_ff   <= '0;
         lp_r_ff   <= '0;
         hs_l_ff   <= '0;
         hs_r_ff   <= '0;
         prev_l_ff <= '0;
         prev_r_ff <= '0;
      end else begin
         lp_l_ff   <= lp_l_in;
         lp_r_ff   <= lp_r_in;
         hs_l_ff   <= hs_l_in;
         hs_r_ff   <= hs_r_in;
         prev_l_ff <= prev_l_in;
         prev_r_ff <= prev_r_in;
      end
   end

   always_ff @(posedge clock) begin
      x_l_ff  <= x_l_in;
      x_r_ff  <= x_r_in;
      last_ff <= last_in;
   end

   // output saturation and result register
   always_comb begin
      sat_l = lane_prod[L_LP_XL];
      if (lane_prod[L_LP_XL] > OUT_MAX) begin
         sat_l = OUT_MAX;
      end else if (lane_prod[L_LP_XL] < OUT_MIN) begin
         sat_l = OUT_MIN;
      end
      sat_r = lane_prod[L_LP_XR];
      if (lane_prod[L_LP_XR] > OUT_MAX) begin
         sat_r = OUT_MAX;
      end else if (lane_prod[L_LP_XR] < OUT_MIN) begin
         sat_r = OUT_MIN;
      end
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      rsp_left_in  = rsp_left_ff;
      rsp_right_in = rsp_right_ff;
      rsp_last_in  = rsp_last_ff;
      if (out_write) begin
         rsp_valid_in = 1'b1;
         rsp_left_in  = sat_l[SAMPLE_BITS-1:0];
         rsp_right_in = sat_r[SAMPLE_BITS-1:0];
         rsp_last_in  = last_ff;
      end else if (rsp_valid_ff & ~rsp_stall) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
      rsp_left_ff  <= rsp_left_in;
      rsp_right_ff <= rsp_right_in;
      rsp_last_ff  <= rsp_last_in;
   end

   assign rsp_valid          = rsp_valid_ff;
   assign rsp_left_out       = rsp_left_ff;
   assign rsp_right_out      = rsp_right_ff;
   assign rsp_last_frame_out = rsp_last_ff;

endmodule
